/* hdl/rmsn_pkg.sv */
// Shared types and constants for the RMS vector normalizer.
// No dependencies; imported by the top level, the root unit and the checker.
`default_nettype none
package rmsn_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOTRDY = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  localparam logic [1:0] CFG_VEC_LEN = 2'd0;
  localparam logic [1:0] CFG_EPSILON = 2'd1;

  localparam logic [23:0] OUT_POS_MAX = 24'h7FFFFF;
  localparam logic [23:0] OUT_NEG_MAG = 24'h800000;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RECIP,
    S_RD_WAIT, S_MUL1, S_MUL2, S_MUL3, S_OUT
  } state_t;

  typedef enum logic [2:0] {R_IDLE, R_DIV, R_CHK, R_REC, R_SQRT, R_DONE} root_state_t;
endpackage
`default_nettype wire

/* hdl/rmsn_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module rmsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/rmsn_root.sv */
// Reciprocal square root unit: divide sum by length, add epsilon, then
// floor(2^40/sqrt(m)) bit-serially, or all ones when m <= 65536. Depends on rmsn_pkg.
`default_nettype none
module rmsn_root
  import rmsn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [59:0] sum,
  input  wire logic [16:0] len,
  input  wire logic [31:0] eps,
  output logic             done,
  output logic      [31:0] result
);
  root_state_t st_r, st_nxt;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] q_r;
  logic [64:0] m_r;
  logic [64:0] m_w;
  logic [64:0] rem_sh;
  logic [63:0] sq_res_r, sq_x_r;
  logic [63:0] div_trial;
  logic [64:0] rec_trial;
  logic [64:0] sq_sum;

  // Sum / len: restoring division, one quotient bit a cycle.
  assign div_trial = {rem_r[62:0], q_r[59]};
  assign rem_sh    = {rem_r, (cnt_r == 7'd80)};
  assign rec_trial = rem_sh;
  assign sq_sum    = {1'b0, sq_res_r} + {1'b0, 64'd1 << {cnt_r[4:0], 1'b0}};
  assign m_w       = {5'd0, q_r[59:0]} + {33'd0, eps};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      R_IDLE: if (start) st_nxt = R_DIV;
      R_DIV:  if (cnt_r == 7'd0) st_nxt = R_CHK;
      R_CHK:  st_nxt = (m_w <= 65'd65536) ? R_DONE : R_REC;
      R_REC:  if (cnt_r == 7'd0) st_nxt = R_SQRT;
      R_SQRT: if (cnt_r == 7'd0) st_nxt = R_DONE;
      R_DONE: st_nxt = R_IDLE;
      default: st_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= R_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      R_IDLE: begin
        rem_r <= '0;
        q_r   <= {4'd0, sum};
        cnt_r <= 7'd59;
      end
      R_DIV: begin
        if (div_trial >= {47'd0, len}) begin
          rem_r <= div_trial - {47'd0, len};
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= div_trial;
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
      end
      R_CHK: begin
        m_r    <= m_w;
        result <= 32'hFFFFFFFF;
        rem_r  <= '0;
        cnt_r  <= 7'd80;
      end
      R_REC: begin
        if (rec_trial >= m_r) begin
          rem_r <= 64'(rec_trial - m_r);
          q_r   <= (cnt_r < 7'd64) ? {q_r[62:0], 1'b1} : q_r;
        end else begin
          rem_r <= rec_trial[63:0];
          q_r   <= (cnt_r < 7'd64) ? {q_r[62:0], 1'b0} : q_r;
        end
        if (cnt_r == 7'd0) begin
          sq_x_r   <= (rec_trial >= m_r) ? {q_r[62:0], 1'b1} : {q_r[62:0], 1'b0};
          sq_res_r <= '0;
          cnt_r    <= 7'd31;
        end else begin
          cnt_r <= cnt_r - 7'd1;
        end
      end
      R_SQRT: begin
        if ({1'b0, sq_x_r} >= sq_sum) begin
          sq_x_r   <= sq_x_r - sq_sum[63:0];
          sq_res_r <= (sq_res_r >> 1) + (64'd1 << {cnt_r[4:0], 1'b0});
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        if (cnt_r == 7'd0) begin
          result <= ({1'b0, sq_x_r} >= sq_sum)
                    ? 32'((sq_res_r >> 1) + 64'd1) : 32'(sq_res_r >> 1);
        end
        cnt_r <= cnt_r - 7'd1;
      end
      default: ;
    endcase
  end

  assign done = (st_r == R_DONE);
endmodule
`default_nettype wire

/* hdl/rms_vector_normalizer.sv */
// RMS vector normalizer top level: control, element memories, output stage.
// Depends on rmsn_pkg, rmsn_ram and rmsn_root.
//
// Usage: in_ transactions carry operation, elem_index, sample and weight_in.
// A load in range stores sample and gain and adds the square to the running
// sum (restarted at index 0); the load at index vec_len-1 triggers the root
// unit, whose result follows 60 division steps, one check, 81 reciprocal steps
// and 32 root steps, the last two skipped when mean plus epsilon is at most
// 65536. Other loads go from S_LOAD to S_OUT. A read passes through the memory
// read, three multiply stages and rounding; a read with an error status goes
// from the memory read to S_OUT. Exactly one out_ transaction per input
// transaction, in order. The block handles one transaction at a time and takes
// the next one in the cycle after the result is registered, even if the
// receiver stalls it there, but no new result is produced until it is taken.
// cfg_ writes take effect immediately and must be made while idle. Synchronous
// active-low reset clears the sum, the root and the ready flag and restores
// vec_len 4096 and epsilon 4295; memories are not cleared.
`default_nettype none
module rms_vector_normalizer
  import rmsn_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [11:0] in_elem_index,
  input  wire logic signed [23:0] in_sample,
  input  wire logic signed [15:0] in_weight_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [23:0] out_value,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  state_t st_r, st_nxt;
  logic [12:0] vec_len_r;
  logic [31:0] eps_r;
  logic [59:0] sum_r;
  logic [59:0] sum_nxt;
  logic [31:0] inv_r;
  logic        ready_r;
  logic        op_r;
  logic [11:0] idx_r;
  logic [23:0] smp_r;
  logic [15:0] gain_r;
  logic [16:0] len;
  logic        idx_ok;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [23:0] s_rd;
  logic [15:0] g_rd;
  logic        root_start, root_done;
  logic [31:0] root_res;
  logic [23:0] sm_r;
  logic [15:0] wmag_r;
  logic        neg_r;
  logic [55:0] a_r;
  logic [55:0] plo_r;
  logic [39:0] phi_r;
  logic [47:0] mag_r;
  logic [47:0] sq;
  logic [23:0] smag;
  logic [23:0] res_val_r;
  logic [1:0]  res_st_r;
  logic        obuf_full_r;
  logic        done_pulse;
  logic [23:0] val_w;
  logic [1:0]  stat_w;

  assign len = (vec_len_r == 13'd0) ? 17'd1 :
               (17'(vec_len_r) > 17'(MAX_LEN)) ? 17'(MAX_LEN) : 17'(vec_len_r);
  assign idx_ok = 17'(idx_r) < len;
  assign smag = smp_r[23] ? 24'(-smp_r) : smp_r;
  assign sq = 48'(smag) * 48'(smag);
  assign sum_nxt = (idx_r == 12'd0) ? 60'(sq) : sum_r + 60'(sq);
  assign in_ready = rst_n && (st_r == S_IDLE);

  // The read address is taken from the input port so that data is ready in S_RD_WAIT.
  assign mem_we   = (st_r == S_LOAD) && idx_ok;
  assign mem_addr = (st_r == S_IDLE) ? AW'(in_elem_index) : AW'(idx_r);
  assign root_start = (st_r == S_LOAD) && idx_ok && (17'(idx_r) == len - 17'd1);

  rmsn_ram #(.WIDTH(24), .DEPTH(MAX_LEN)) u_sample_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(smp_r), .rdata(s_rd));
  rmsn_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_gain_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(gain_r), .rdata(g_rd));

  rmsn_root u_root (
    .clk(clk), .rst_n(rst_n), .start(root_start), .sum(sum_nxt),
    .len(len), .eps(eps_r),
    .done(root_done), .result(root_res));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:    if (in_valid && in_ready) st_nxt = (in_operation == OP_READ) ? S_RD_WAIT
                                                                             : S_LOAD;
      S_LOAD:    st_nxt = root_start ? S_RECIP : S_OUT;
      S_RECIP:   if (root_done) st_nxt = S_OUT;
      S_RD_WAIT: st_nxt = (ready_r && idx_ok) ? S_MUL1 : S_OUT;
      S_MUL1:    st_nxt = S_MUL2;
      S_MUL2:    st_nxt = S_MUL3;
      S_MUL3:    st_nxt = S_OUT;
      S_OUT:     if (!obuf_full_r || out_ready) st_nxt = S_IDLE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  // Result value and status for the output register.
  always_comb begin
    val_w  = '0;
    stat_w = ST_OK;
    if (op_r == OP_LOAD) begin
      stat_w = idx_ok ? ST_OK : ST_RANGE;
    end else if (!ready_r) begin
      stat_w = ST_NOTRDY;
    end else if (!idx_ok) begin
      stat_w = ST_RANGE;
    end else if (neg_r && mag_r != 48'd0) begin
      if (mag_r > 48'(OUT_NEG_MAG)) begin
        val_w  = OUT_NEG_MAG;
        stat_w = ST_SAT;
      end else begin
        val_w = 24'(-mag_r[23:0]);
      end
    end else if (mag_r > 48'(OUT_POS_MAX)) begin
      val_w  = OUT_POS_MAX;
      stat_w = ST_SAT;
    end else begin
      val_w = mag_r[23:0];
    end
  end

  assign done_pulse = (st_r == S_OUT) && (!obuf_full_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      vec_len_r   <= 13'd4096;
      eps_r       <= 32'd4295;
      sum_r       <= '0;
      inv_r       <= '0;
      ready_r     <= 1'b0;
      obuf_full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_index == CFG_VEC_LEN) vec_len_r <= cfg_data[12:0];
      if (cfg_we && cfg_index == CFG_EPSILON) eps_r <= cfg_data;
      if (st_r == S_LOAD && idx_ok) begin
        sum_r <= sum_nxt;
        if (idx_r == 12'd0) ready_r <= 1'b0;
      end
      if (st_r == S_RECIP && root_done) begin
        inv_r   <= root_res;
        ready_r <= 1'b1;
      end
      if (done_pulse) begin
        obuf_full_r <= 1'b1;
      end else if (out_ready) begin
        obuf_full_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      idx_r  <= in_elem_index;
      smp_r  <= in_sample;
      gain_r <= in_weight_in;
    end
    // Three registered multiply stages, each at most 32x24 bits.
    if (st_r == S_RD_WAIT) begin
      sm_r   <= s_rd[23] ? 24'(-s_rd) : s_rd;
      wmag_r <= g_rd[15] ? 16'(-g_rd) : g_rd;
      neg_r  <= s_rd[23] ^ g_rd[15];
    end
    if (st_r == S_MUL1) a_r <= 56'(sm_r) * 56'(inv_r);
    if (st_r == S_MUL2) begin
      plo_r <= 56'(a_r[31:0]) * 56'(wmag_r) + (56'd1 << 35);
      phi_r <= 40'(a_r[55:32]) * 40'(wmag_r);
    end
    if (st_r == S_MUL3) begin
      mag_r <= 48'(phi_r >> 4) + 48'(({24'd0, phi_r[3:0], 32'd0} + {4'd0, plo_r}) >> 36);
    end
    if (done_pulse) begin
      res_val_r <= val_w;
      res_st_r  <= stat_w;
    end
  end

  assign out_valid  = obuf_full_r;
  assign out_value  = res_val_r;
  assign out_status = res_st_r;
endmodule
`default_nettype wire

/* hdl/rmsn_checker.sv */
// Port-level checker for the RMS vector normalizer, bound to the top level.
// Depends on rmsn_pkg.
`default_nettype none
module rmsn_checker
  import rmsn_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] out_value,
  input wire logic [1:0]  out_status
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result dropped under stall");
  a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOTRDY || out_status == ST_RANGE) |-> out_value == 24'd0)
    else $error("nonzero value with error status");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_status))
    else $error("unknown status on a valid result");
endmodule

bind rms_vector_normalizer rmsn_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
  .out_status(out_status));
`default_nettype wire
